[rtl/gbfv_pkg.sv]
// ----------------------------------------------------------------------------
// gbfv_pkg
// shared constants and the cordic arctangent table for the velocity core
// ----------------------------------------------------------------------------
package gbfv_pkg;

   localparam int unsigned USEC_PER_SEC = 1000000;
   localparam int unsigned DIV_BITS     = 52;          // width of mag * 1e6 + dt/2
   localparam int unsigned CORDIC_STEPS = 15;
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032875;
   localparam logic signed [33:0] Q15_HALF = 34'sd16384;

   // fsm codes
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PREP = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_CLMP = 3'd3;
   localparam logic [2:0] ST_ROT  = 3'd4;
   localparam logic [2:0] ST_RND  = 3'd5;

   // arctangent of 2^-i in binary angle units
   function automatic logic [13:0] atan_bam(input logic [3:0] idx);
      logic [13:0] r;
      begin
         case (idx)
            4'd0:    r = 14'd8192;
            4'd1:    r = 14'd4836;
            4'd2:    r = 14'd2555;
            4'd3:    r = 14'd1297;
            4'd4:    r = 14'd651;
            4'd5:    r = 14'd326;
            4'd6:    r = 14'd163;
            4'd7:    r = 14'd81;
            4'd8:    r = 14'd41;
            4'd9:    r = 14'd20;
            4'd10:   r = 14'd10;
            4'd11:   r = 14'd5;
            4'd12:   r = 14'd3;
            4'd13:   r = 14'd1;
            4'd14:   r = 14'd1;
            default: r = 14'd0;
         endcase
         return r;
      end
   endfunction

endpackage

[rtl/gps_body_frame_velocity_core.sv]
// ----------------------------------------------------------------------------
// gps_body_frame_velocity_core
// finite-difference gps velocity rotated into the body frame
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one position/yaw/time beat, rsp_* one body velocity beat.
//   csr_* carries initial_time; until the first req beat it sets the
//   previous timestamp, after it has no effect. csr_ready is always high.
//   a req beat is taken only when the core is idle. it then runs a setup
//   step, restoring division (one quotient bit per cycle, x and y side by
//   side, the 15-step cordic overlapping), a clamp step, the products
//   through one shared 32x16 multiplier and a rounding step. a beat is not
//   taken while the previous one is still being worked on.
//   the result sits in an output register; the next req beat is taken as
//   soon as that register is loaded, even if rsp_tready is low. a new result
//   waits in the rounding stage until the output register frees up.
//   reset clears the previous position to zero, the previous time to zero
//   and drops rsp_tvalid.
// ----------------------------------------------------------------------------
module gps_body_frame_velocity_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // pos_x[31:0], pos_y[63:32], yaw_angle[79:64], timestamp[111:80],
   // fallback_dt[143:112]
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // vel_forward[31:0], vel_lateral[63:32], dt_used[95:64]
   output logic [95:0]  rsp_tdata,
   // saturated[0]
   output logic         rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_data
);

   localparam int unsigned DB = gbfv_pkg::DIV_BITS;

   logic [2:0] state_ff, state_in;
   logic       started_ff;
   logic signed [31:0] prev_x_ff, prev_y_ff;
   logic [31:0] prev_time_ff;

   // per-item working registers
   logic [31:0] dt_ff;
   logic        neg_x_ff, neg_y_ff;
   logic [32:0] mag_x_ff, mag_y_ff;
   logic [DB-1:0] num_x_ff, num_y_ff;   // dividend, shifts into quotient
   logic [31:0] rem_x_ff, rem_y_ff;
   logic [5:0]  div_cnt_ff;
   logic signed [33:0] cx_ff, cy_ff;
   logic signed [17:0] cz_ff;
   logic        flip_ff;
   logic [3:0]  cor_cnt_ff;
   logic signed [31:0] vx_ff, vy_ff;
   logic signed [15:0] cos_ff, sin_ff;
   logic        sat_ff;
   logic [2:0]  rot_cnt_ff;
   logic signed [47:0] prod_ff;
   logic signed [48:0] acc_f_ff, acc_l_ff;

   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic        rsp_sat_ff;

   logic accept, load_out;
   assign req_tready = (state_ff == gbfv_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // input fields
   logic signed [31:0] in_px, in_py;
   logic signed [15:0] in_yaw;
   logic [31:0] in_ts, in_fb;
   assign in_px  = req_tdata[31:0];
   assign in_py  = req_tdata[63:32];
   assign in_yaw = req_tdata[79:64];
   assign in_ts  = req_tdata[111:80];
   assign in_fb  = req_tdata[143:112];

   // deltas and interval at accept
   logic signed [32:0] dx, dy;
   logic [31:0] dt_sel;
   logic signed [16:0] yaw_fold;
   logic        yaw_flip;
   always_comb begin
      dx = {in_px[31], in_px} - {prev_x_ff[31], prev_x_ff};
      dy = {in_py[31], in_py} - {prev_y_ff[31], prev_y_ff};
      if (in_ts > prev_time_ff) begin
         dt_sel = in_ts - prev_time_ff;
      end else begin
         dt_sel = (in_fb == 32'd0) ? 32'd1 : in_fb;
      end
      // fold yaw into [-quarter, quarter) turn
      yaw_flip = 1'b0;
      yaw_fold = {in_yaw[15], in_yaw};
      if (in_yaw > 16'sd16383) begin
         yaw_fold = yaw_fold - 17'sd32768;
         yaw_flip = 1'b1;
      end else if (in_yaw < -16'sd16384) begin
         yaw_fold = yaw_fold + 17'sd32768;
         yaw_flip = 1'b1;
      end
   end

   // one restoring division bit per cycle for each axis
   logic [32:0] rx2, ry2;
   logic        gex, gey;
   always_comb begin
      rx2 = {rem_x_ff, num_x_ff[DB-1]};
      ry2 = {rem_y_ff, num_y_ff[DB-1]};
      gex = rx2 >= {1'b0, dt_ff};
      gey = ry2 >= {1'b0, dt_ff};
   end

   // cordic micro-rotation
   logic signed [33:0] sh_x, sh_y;
   logic signed [17:0] at;
   assign sh_x = cx_ff >>> cor_cnt_ff;
   assign sh_y = cy_ff >>> cor_cnt_ff;
   assign at   = 18'(gbfv_pkg::atan_bam(cor_cnt_ff));

   // quotient clamp and q1.15 sine/cosine
   logic signed [33:0] fx, fy, tx, ty;
   logic signed [15:0] cos_q, sin_q;
   logic signed [31:0] vx_c, vy_c;
   logic sx, sy;
   always_comb begin
      fx = flip_ff ? -cx_ff : cx_ff;
      fy = flip_ff ? -cy_ff : cy_ff;
      tx = (fx + gbfv_pkg::Q15_HALF) >>> 15;
      ty = (fy + gbfv_pkg::Q15_HALF) >>> 15;
      cos_q = (tx > 34'sd32767) ? 16'sd32767 :
              (tx < -34'sd32768) ? -16'sd32768 : tx[15:0];
      sin_q = (ty > 34'sd32767) ? 16'sd32767 :
              (ty < -34'sd32768) ? -16'sd32768 : ty[15:0];
      sx = neg_x_ff ? (num_x_ff > DB'(64'd2147483648))
                    : (num_x_ff > DB'(64'd2147483647));
      sy = neg_y_ff ? (num_y_ff > DB'(64'd2147483648))
                    : (num_y_ff > DB'(64'd2147483647));
      if (sx) begin
         vx_c = neg_x_ff ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         vx_c = neg_x_ff ? -$signed(num_x_ff[31:0]) : $signed(num_x_ff[31:0]);
      end
      if (sy) begin
         vy_c = neg_y_ff ? 32'sh80000000 : 32'sh7fffffff;
      end else begin
         vy_c = neg_y_ff ? -$signed(num_y_ff[31:0]) : $signed(num_y_ff[31:0]);
      end
   end

   // shared multiplier: vx*c, vy*s, vy*c, vx*s
   logic signed [31:0] mul_a;
   logic signed [15:0] mul_b;
   always_comb begin
      case (rot_cnt_ff)
         3'd0:    begin mul_a = vx_ff; mul_b = cos_ff; end
         3'd1:    begin mul_a = vy_ff; mul_b = sin_ff; end
         3'd2:    begin mul_a = vy_ff; mul_b = cos_ff; end
         default: begin mul_a = vx_ff; mul_b = sin_ff; end
      endcase
   end

   // final rounding and saturation
   logic signed [33:0] rf, rl;
   logic signed [31:0] vf_c, vl_c;
   logic sf, sl;
   always_comb begin
      rf = 34'((acc_f_ff + 49'sd16384) >>> 15);
      rl = 34'((acc_l_ff + 49'sd16384) >>> 15);
      sf = (rf > 34'sd2147483647) || (rf < -34'sd2147483648);
      sl = (rl > 34'sd2147483647) || (rl < -34'sd2147483648);
      vf_c = sf ? (rf[33] ? 32'sh80000000 : 32'sh7fffffff) : rf[31:0];
      vl_c = sl ? (rl[33] ? 32'sh80000000 : 32'sh7fffffff) : rl[31:0];
   end

   assign load_out = (state_ff == gbfv_pkg::ST_RND) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gbfv_pkg::ST_IDLE: if (accept) state_in = gbfv_pkg::ST_PREP;
         gbfv_pkg::ST_PREP: state_in = gbfv_pkg::ST_DIV;
         gbfv_pkg::ST_DIV:  if (div_cnt_ff == 6'(DB - 1)) state_in = gbfv_pkg::ST_CLMP;
         gbfv_pkg::ST_CLMP: state_in = gbfv_pkg::ST_ROT;
         gbfv_pkg::ST_ROT:  if (rot_cnt_ff == 3'd4) state_in = gbfv_pkg::ST_RND;
         gbfv_pkg::ST_RND:  if (load_out) state_in = gbfv_pkg::ST_IDLE;
         default:           state_in = gbfv_pkg::ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbfv_pkg::ST_IDLE;
         started_ff   <= 1'b0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         prev_time_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && !started_ff) prev_time_ff <= csr_data;
         if (accept) begin
            started_ff   <= 1'b1;
            prev_x_ff    <= in_px;
            prev_y_ff    <= in_py;
            prev_time_ff <= in_ts;
         end
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         gbfv_pkg::ST_IDLE: begin
            dt_ff      <= dt_sel;
            neg_x_ff   <= dx[32];
            neg_y_ff   <= dy[32];
            mag_x_ff   <= dx[32] ? 33'(-dx) : 33'(dx);
            mag_y_ff   <= dy[32] ? 33'(-dy) : 33'(dy);
            cx_ff      <= gbfv_pkg::CORDIC_GAIN_Q30;
            cy_ff      <= '0;
            cz_ff      <= 18'(yaw_fold);
            flip_ff    <= yaw_flip;
            cor_cnt_ff <= '0;
         end
         gbfv_pkg::ST_PREP: begin
            num_x_ff   <= DB'(mag_x_ff) * DB'(gbfv_pkg::USEC_PER_SEC) + DB'(dt_ff >> 1);
            num_y_ff   <= DB'(mag_y_ff) * DB'(gbfv_pkg::USEC_PER_SEC) + DB'(dt_ff >> 1);
            rem_x_ff   <= '0;
            rem_y_ff   <= '0;
            div_cnt_ff <= '0;
         end
         gbfv_pkg::ST_DIV: begin
            rem_x_ff   <= gex ? 32'(rx2 - {1'b0, dt_ff}) : rx2[31:0];
            rem_y_ff   <= gey ? 32'(ry2 - {1'b0, dt_ff}) : ry2[31:0];
            num_x_ff   <= {num_x_ff[DB-2:0], gex};
            num_y_ff   <= {num_y_ff[DB-2:0], gey};
            div_cnt_ff <= div_cnt_ff + 6'd1;
            if (cor_cnt_ff < 4'(gbfv_pkg::CORDIC_STEPS)) begin
               if (cz_ff >= 0) begin
                  cx_ff <= cx_ff - sh_y;
                  cy_ff <= cy_ff + sh_x;
                  cz_ff <= cz_ff - at;
               end else begin
                  cx_ff <= cx_ff + sh_y;
                  cy_ff <= cy_ff - sh_x;
                  cz_ff <= cz_ff + at;
               end
               cor_cnt_ff <= cor_cnt_ff + 4'd1;
            end
         end
         gbfv_pkg::ST_CLMP: begin
            vx_ff      <= vx_c;
            vy_ff      <= vy_c;
            cos_ff     <= cos_q;
            sin_ff     <= sin_q;
            sat_ff     <= sx || sy;
            rot_cnt_ff <= '0;
            acc_f_ff   <= '0;
            acc_l_ff   <= '0;
         end
         gbfv_pkg::ST_ROT: begin
            prod_ff    <= mul_a * mul_b;
            rot_cnt_ff <= rot_cnt_ff + 3'd1;
            case (rot_cnt_ff)
               3'd1:    acc_f_ff <= acc_f_ff + 49'(prod_ff);
               3'd2:    acc_f_ff <= acc_f_ff + 49'(prod_ff);
               3'd3:    acc_l_ff <= acc_l_ff + 49'(prod_ff);
               3'd4:    acc_l_ff <= acc_l_ff - 49'(prod_ff);
               default: ;
            endcase
         end
         gbfv_pkg::ST_RND: begin
            if (load_out) begin
               rsp_data_ff <= {dt_ff, vl_c, vf_c};
               rsp_sat_ff  <= sat_ff || sf || sl;
            end
         end
         default: ;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   // an accepted beat moves the core into setup
   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == gbfv_pkg::ST_PREP)
      else $error("accepted beat did not start setup");

   // divider remainder always below the divisor
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == gbfv_pkg::ST_DIV |-> (rem_x_ff < dt_ff) && (rem_y_ff < dt_ff))
      else $error("division remainder out of range");

   // interval is never zero while working
   a_dt_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == gbfv_pkg::ST_DIV |-> dt_ff != 32'd0)
      else $error("zero interval in divider");

   // cordic finishes before the divider does
   a_cordic_done: assert property (@(posedge clock) disable iff (reset)
      state_ff == gbfv_pkg::ST_CLMP |-> cor_cnt_ff == 4'(gbfv_pkg::CORDIC_STEPS))
      else $error("cordic not finished at clamp");

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// regression for gps_body_frame_velocity_core: directed corner beats, then
// random position tracks under three idle patterns, each result checked
// against a bit-exact velocity predictor
// ----------------------------------------------------------------------------
class velocity_scoreboard;
   // predictor state
   logic [31:0] start_time;
   logic signed [31:0] last_x;
   logic signed [31:0] last_y;
   logic [31:0] last_ts;
   bit          stepped;
   logic [96:0] pending_rsp[$];   // {saturated, dt_used, vel_lateral, vel_forward}
   int          errors;

   function new();
      start_time = '0;
      last_x     = '0;
      last_y     = '0;
      last_ts    = '0;
      stepped    = 0;
      errors     = 0;
   endfunction

   function void write_start_time(logic [31:0] value);
      start_time = value;
      if (!stepped) last_ts = value;
   endfunction

   // floor shift for signed 64 bit
   static function longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   static function longint sat32(longint v, ref bit sat);
      if (v > 64'sd2147483647) begin
         sat = 1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         sat = 1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   static function longint clip_q15(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   static function void heading_sin_cos(int angle, output longint s, output longint c);
      int     arctan[15];
      bit     flip;
      longint x, y, nx;
      int     z;
      arctan = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1};
      flip = 0;
      x = 652032875;
      y = 0;
      if (angle > 16383) begin
         angle -= 32768;
         flip = 1;
      end else if (angle < -16384) begin
         angle += 32768;
         flip = 1;
      end
      z = angle;
      for (int i = 0; i < 15; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            y  = y + (x >>> i);
            z -= arctan[i];
         end else begin
            nx = x + (y >>> i);
            y  = y - (x >>> i);
            z += arctan[i];
         end
         x = nx;
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clip_q15((x + 16384) >>> 15);
      s = clip_q15((y + 16384) >>> 15);
   endfunction

   static function longint rate_of(longint delta, logic [31:0] dt, ref bit sat);
      logic [63:0] mag, q;
      longint      v;
      mag = (delta < 0 ? -delta : delta) * 64'd1000000;
      q   = (mag + {32'd0, dt} / 2) / {32'd0, dt};
      v   = delta < 0 ? -longint'(q) : longint'(q);
      return sat32(v, sat);
   endfunction

   function void note_position(logic [143:0] beat);
      logic signed [31:0] px, py;
      logic signed [15:0] yaw;
      logic [31:0] ts, fb, dt;
      bit          sat;
      longint      vx, vy, s, c, vf, vl;
      px  = beat[31:0];
      py  = beat[63:32];
      yaw = beat[79:64];
      ts  = beat[111:80];
      fb  = beat[143:112];
      sat = 0;
      if (ts > last_ts) dt = ts - last_ts;
      else dt = (fb != 0) ? fb : 32'd1;
      vx = rate_of(longint'(px) - longint'(last_x), dt, sat);
      vy = rate_of(longint'(py) - longint'(last_y), dt, sat);
      heading_sin_cos(int'(yaw), s, c);
      vf = sat32((vx * c + vy * s + 16384) >>> 15, sat);
      vl = sat32((vy * c - vx * s + 16384) >>> 15, sat);
      last_x  = px;
      last_y  = py;
      last_ts = ts;
      stepped = 1;
      pending_rsp.push_back({sat, dt, vl[31:0], vf[31:0]});
   endfunction

   function void check_velocity(logic [95:0] data, logic sat);
      logic [96:0] exp_rsp;
      if (pending_rsp.size() == 0) begin
         $display("%0t: unexpected rsp beat %h sat %b", $time, data, sat);
         errors++;
         return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (data[31:0] !== exp_rsp[31:0]) begin
         $display("%0t: vel_forward expected %h actual %h", $time, exp_rsp[31:0], data[31:0]);
         errors++;
      end
      if (data[63:32] !== exp_rsp[63:32]) begin
         $display("%0t: vel_lateral expected %h actual %h", $time, exp_rsp[63:32],
                  data[63:32]);
         errors++;
      end
      if (data[95:64] !== exp_rsp[95:64]) begin
         $display("%0t: dt_used expected %h actual %h", $time, exp_rsp[95:64], data[95:64]);
         errors++;
      end
      if (sat !== exp_rsp[96]) begin
         $display("%0t: saturated expected %b actual %b", $time, exp_rsp[96], sat);
         errors++;
      end
   endfunction
endclass

module tb;
   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [31:0]  csr_data;

   velocity_scoreboard sb;
   int  send_idle_pct;   // chance per cycle that the sender holds back
   int  recv_idle_pct;   // chance per cycle that the receiver stalls
   bit  hold_off;        // long receiver stall for back-pressure
   longint cycle_count;

   // track of the simulated vehicle
   logic [31:0] track_x, track_y, track_ts;

   gps_body_frame_velocity_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   // timeout: ~1700 beats plus stalls, with a wide margin
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 64'd1500000) begin
         $display("gps_body_frame_velocity_core regression: fail");
         $finish;
      end
   end

   // receiver side: random stalls plus an optional long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_velocity(rsp_tdata, rsp_tuser);
         rsp_tready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // one req beat, with random idle cycles in front; tvalid stays up after
   // the beat so that back to back beats see one drive per clock
   task automatic send_beat(logic [31:0] px, logic [31:0] py, logic [15:0] yaw,
                            logic [31:0] ts, logic [31:0] fb);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata  <= {fb, ts, yaw, py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_position({fb, ts, yaw, py, px});
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (sb.pending_rsp.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_start_time(logic [31:0] value);
      csr_valid <= 1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_start_time(value);
      csr_valid <= 0;
   endtask

   function automatic logic [31:0] rand_word();
      return $urandom();
   endfunction

   // well-formed track step: small moves, forward time; sometimes noise
   task automatic send_track_step();
      int kind;
      logic [31:0] fb;
      kind = $urandom_range(99);
      fb   = ($urandom_range(9) == 0) ? rand_word() : $urandom_range(2000, 1);
      if (kind < 75) begin
         track_x  += $signed($urandom_range(200000)) - 100000;
         track_y  += $signed($urandom_range(200000)) - 100000;
         track_ts += $urandom_range(5000, 1);
      end else if (kind < 85) begin
         // stale or repeated time: fallback path
         track_x  += $signed($urandom_range(2000)) - 1000;
         track_ts -= $urandom_range(3);
         if ($urandom_range(4) == 0) fb = 0;
      end else begin
         // jump: large deltas and wild times, often saturating
         track_x  = rand_word();
         track_y  = rand_word();
         track_ts = rand_word();
      end
      send_beat(track_x, track_y, 16'($urandom()), track_ts, fb);
   endtask

   initial begin
      sb = new();
      cycle_count = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      csr_valid = 0;
      csr_data = '0;
      hold_off = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // start time at the top, so the first beat takes the fallback
      write_start_time(32'hFFFF_FFFF);
      send_beat(32'h0001_0000, 32'hFFFF_0000, 16'h0000, 32'd100, 32'd1000);
      wait_drained();
      // late write after stepping leaves the previous timestamp alone
      write_start_time(32'd0);

      // directed: field extremes, all quadrants, zero fallback, saturation
      send_beat(32'h7FFF_FFFF, 32'h8000_0000, 16'h4000, 32'd101, 32'd7);
      send_beat(32'h8000_0000, 32'h7FFF_FFFF, 16'hC000, 32'd101, 32'd0);
      send_beat(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 32'd50, 32'hFFFF_FFFF);
      send_beat(32'h0000_0000, 32'h0000_0000, 16'h7FFF, 32'hFFFF_FFFF, 32'd1);
      send_beat(32'h0000_0001, 32'hFFFF_FFFF, 16'h3FFF, 32'd0, 32'd0);
      send_beat(32'h0000_0002, 32'hFFFF_FFFE, 16'hBFFF, 32'd1, 32'd3);
      send_beat(32'h0000_0003, 32'hFFFF_FFFD, 16'h2000, 32'd3, 32'd1);
      send_beat(32'h0001_0000, 32'h0001_0000, 16'hE000, 32'd1003, 32'd1);
      send_beat(32'h0002_0000, 32'h0000_0000, 16'h6000, 32'd2003, 32'd1);
      send_beat(32'hFFFF_FFFF, 32'h0000_0000, 16'hA000, 32'd2003, 32'hAAAA_AAAA);
      send_beat(32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, 32'h8000_0000, 32'h5555_5555);
      send_beat(32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, 32'h8000_0001, 32'd1);
      wait_drained();

      track_x = 0;
      track_y = 0;
      track_ts = 32'h8000_0001;

      // phase 1: sender idles a little, receiver a lot
      send_idle_pct = 8;
      recv_idle_pct = 61;
      repeat (550) send_track_step();

      // long receiver hold-off while the sender keeps offering
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         repeat (6) send_track_step();
      join
      wait_drained();

      // phase 2: roles swapped
      send_idle_pct = 61;
      recv_idle_pct = 8;
      repeat (550) send_track_step();
      wait_drained();

      // phase 3: no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (550) send_track_step();
      wait_drained();

      if (sb.errors == 0) begin
         $display("gps_body_frame_velocity_core regression: pass");
      end else begin
         $display("gps_body_frame_velocity_core regression: fail");
      end
      $finish;
   end
endmodule
